[src/cuwa_pkg.sv]
// Shared types, constants and codes of the CPU utilization window averager.
package cuwa_pkg;

  localparam int HIST_DEPTH = 1024;
  localparam int NUM_CPUS   = 8;
  localparam int NSLOT      = NUM_CPUS + 1;
  localparam int NENT       = NSLOT * HIST_DEPTH;
  localparam int AW         = $clog2(NENT);
  localparam int IW         = $clog2(HIST_DEPTH);
  localparam int NCAT       = 8;
  localparam int NWIN       = 3;
  localparam int CNT_W      = 64;
  localparam int SUM_W      = CNT_W + 3;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int WIN_W      = 16;
  localparam int CAT_W      = 3;
  localparam int PCT_W      = 15;
  localparam int REM_W      = SUM_W + PCT_W;
  localparam int IN_DATA_W  = 552;
  localparam int OUT_DATA_W = 56;

  localparam logic [PCT_W-1:0] FULL_SCALE = 15'd25600;
  localparam logic [CAT_W-1:0] LAST_CAT   = 3'd7;

  localparam logic [1:0] CFG_WIN_SHORT = 2'd0;
  localparam logic [1:0] CFG_WIN_MID   = 2'd1;
  localparam logic [1:0] CFG_WIN_LONG  = 2'd2;

  typedef struct packed {
    logic                             slot_ok;
    logic [SLOT_W-1:0]                cpu_index;
    logic [TIME_W-1:0]                sample_time;
    logic [NCAT-1:0][CNT_W-1:0]       ticks;
  } item_t;

  typedef struct packed {
    logic ready;
    logic pop;
  } eng_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN1, ST_SCAN2, ST_FETCH_RD, ST_FETCH_WT,
    ST_SUM, ST_DIV, ST_EMIT
  } eng_state_e;

  typedef enum logic [1:0] {
    DV_IDLE, DV_PREP, DV_RUN
  } div_state_e;

endpackage

[src/cuwa_front.sv]
// Input queue: unpacks and classifies sample beats for the engine.
module cuwa_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cuwa_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  cuwa_pkg::eng_stat_t            stat_i,
  output logic                           item_valid_o,
  output cuwa_pkg::item_t                item_o
);

  cuwa_pkg::item_t  mem_q [2];
  cuwa_pkg::item_t  in_item;
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push;

  always_comb begin
    in_item.cpu_index   = s_axis_tdata[3:0];
    in_item.sample_time = s_axis_tdata[35:4];
    for (int k = 0; k < cuwa_pkg::NCAT; k++) begin
      in_item.ticks[k] = s_axis_tdata[36 + 64*k +: 64];
    end
    in_item.slot_ok = (32'(in_item.cpu_index) <= cuwa_pkg::NUM_CPUS);
  end

  assign s_axis_tready = stat_i.ready && (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (stat_i.pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(stat_i.pop);
    end
  end

endmodule

[src/cuwa_div.sv]
// Restoring divider: floor(25600*dt/da) with zero and saturation cases.
module cuwa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cuwa_pkg::CNT_W-1:0]    cur_i,
  input  logic [cuwa_pkg::CNT_W-1:0]    base_i,
  input  logic [cuwa_pkg::SUM_W-1:0]    sum_cur_i,
  input  logic [cuwa_pkg::SUM_W-1:0]    sum_base_i,
  output logic                          done_o,
  output logic [cuwa_pkg::PCT_W-1:0]    q_o
);

  cuwa_pkg::div_state_e            state_q, state_d;
  logic                            pos_q, pos_d;
  logic [cuwa_pkg::CNT_W-1:0]      dt_q, dt_d;
  logic [cuwa_pkg::SUM_W-1:0]      da_q, da_d;
  logic [cuwa_pkg::REM_W-1:0]      rem_q, rem_d, ds_q, ds_d, num;
  logic [cuwa_pkg::PCT_W-1:0]      q_q, q_d, acc_q, acc_d, acc_n;
  logic [3:0]                      cnt_q, cnt_d;
  logic                            done_q, done_d;

  assign done_o = done_q;
  assign q_o    = q_q;
  assign num    = (cuwa_pkg::REM_W'(dt_q) << 14) + (cuwa_pkg::REM_W'(dt_q) << 13)
                + (cuwa_pkg::REM_W'(dt_q) << 10);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    dt_d    = dt_q;
    da_d    = da_q;
    rem_d   = rem_q;
    ds_d    = ds_q;
    q_d     = q_q;
    acc_d   = acc_q;
    acc_n   = acc_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      cuwa_pkg::DV_IDLE: begin
        if (start_i) begin
          pos_d   = (cur_i > base_i) && (sum_cur_i > sum_base_i);
          dt_d    = cur_i - base_i;
          da_d    = sum_cur_i - sum_base_i;
          state_d = cuwa_pkg::DV_PREP;
        end
      end
      cuwa_pkg::DV_PREP: begin
        if (!pos_q) begin
          q_d     = '0;
          done_d  = 1'b1;
          state_d = cuwa_pkg::DV_IDLE;
        end else if (!(da_q > cuwa_pkg::SUM_W'(dt_q))) begin
          q_d     = cuwa_pkg::FULL_SCALE;
          done_d  = 1'b1;
          state_d = cuwa_pkg::DV_IDLE;
        end else begin
          rem_d   = num;
          ds_d    = cuwa_pkg::REM_W'(da_q) << 14;
          acc_d   = '0;
          cnt_d   = 4'd14;
          state_d = cuwa_pkg::DV_RUN;
        end
      end
      cuwa_pkg::DV_RUN: begin
        if (ds_q <= rem_q) begin
          rem_d = rem_q - ds_q;
          acc_n = acc_q | (cuwa_pkg::PCT_W'(1) << cnt_q);
        end
        acc_d = acc_n;
        ds_d  = ds_q >> 1;
        if (cnt_q == 4'd0) begin
          q_d     = (acc_n > cuwa_pkg::FULL_SCALE) ? cuwa_pkg::FULL_SCALE : acc_n;
          done_d  = 1'b1;
          state_d = cuwa_pkg::DV_IDLE;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      default: state_d = cuwa_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    dt_q  <= dt_d;
    da_q  <= da_d;
    rem_q <= rem_d;
    ds_q  <= ds_d;
    q_q   <= q_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cuwa_pkg::DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

[src/cuwa_engine.sv]
// Back end: history memories, free-entry and window scans, sums and results.
module cuwa_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [cuwa_pkg::WIN_W-1:0]       win_i [cuwa_pkg::NWIN],
  input  logic                             item_valid_i,
  input  cuwa_pkg::item_t                  item_i,
  output cuwa_pkg::eng_stat_t              stat_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [cuwa_pkg::CAT_W-1:0]       res_cat_o,
  output logic [cuwa_pkg::PCT_W-1:0]       res_pct_o [cuwa_pkg::NWIN],
  output logic                             res_stored_o,
  output logic                             res_last_o
);

  localparam int NW = cuwa_pkg::NWIN;
  localparam int NC = cuwa_pkg::NCAT;
  localparam int TW = cuwa_pkg::TIME_W;
  localparam int AW = cuwa_pkg::AW;
  localparam int IW = cuwa_pkg::IW;

  logic [TW-1:0]                      tmem [cuwa_pkg::NENT];
  logic [NC-1:0][cuwa_pkg::CNT_W-1:0] cmem [cuwa_pkg::NENT];

  logic                               t_we, c_we;
  logic [AW-1:0]                      t_wa, t_ra, c_ra;
  logic [TW-1:0]                      t_wd, t_rd_q;
  logic [NC-1:0][cuwa_pkg::CNT_W-1:0] c_rd_q;

  cuwa_pkg::eng_state_e               state_q, state_d;
  logic [AW-1:0]                      clr_q, clr_d;
  logic [IW:0]                        idx_q, idx_d;
  logic                               chk_v_q, chk_v_d;
  logic [IW-1:0]                      chk_idx_q, chk_idx_d;
  logic [AW-1:0]                      base_addr_q, base_addr_d;
  cuwa_pkg::item_t                    item_q, item_d;
  logic [NC-1:0][cuwa_pkg::CNT_W-1:0] cur_q, cur_d;
  logic                               stored_q, stored_d;
  logic [TW:0]                        btime_q [NW];
  logic [TW:0]                        btime_d [NW];
  logic [IW-1:0]                      best_q [NW];
  logic [IW-1:0]                      best_d [NW];
  logic [NW-1:0]                      found_q, found_d, under_q, under_d;
  logic [TW-1:0]                      lo_q [NW];
  logic [TW-1:0]                      lo_d [NW];
  logic [1:0]                         fw_q, fw_d, win_q, win_d;
  logic [NC-1:0][cuwa_pkg::CNT_W-1:0] base_q [NW];
  logic [NC-1:0][cuwa_pkg::CNT_W-1:0] base_d [NW];
  logic [cuwa_pkg::CAT_W-1:0]         sk_q, sk_d, cat_q, cat_d;
  logic [cuwa_pkg::SUM_W-1:0]         sc_q, sc_d;
  logic [cuwa_pkg::SUM_W-1:0]         sb_q [NW];
  logic [cuwa_pkg::SUM_W-1:0]         sb_d [NW];
  logic [cuwa_pkg::PCT_W-1:0]         pct_q [NW];
  logic [cuwa_pkg::PCT_W-1:0]         pct_d [NW];
  logic                               div_go_q, div_go_d, div_start, div_done;
  logic [cuwa_pkg::PCT_W-1:0]         div_q;
  logic                               free;

  assign free = ({1'b0, t_rd_q} + (TW+1)'(cuwa_pkg::HIST_DEPTH))
              < {1'b0, item_q.sample_time};

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    t_rd_q <= tmem[t_ra];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[t_wa] <= item_q.ticks;
    end
    c_rd_q <= cmem[c_ra];
  end

  cuwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .cur_i      (cur_q[cat_q]),
    .base_i     (base_q[win_q][cat_q]),
    .sum_cur_i  (sc_q),
    .sum_base_i (sb_q[win_q]),
    .done_o     (div_done),
    .q_o        (div_q)
  );

  assign res_valid_o  = (state_q == cuwa_pkg::ST_EMIT);
  assign res_cat_o    = cat_q;
  assign res_pct_o    = pct_q;
  assign res_stored_o = stored_q;
  assign res_last_o   = (cat_q == cuwa_pkg::LAST_CAT);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    base_addr_d = base_addr_q;
    item_d      = item_q;
    cur_d       = cur_q;
    stored_d    = stored_q;
    btime_d     = btime_q;
    best_d      = best_q;
    found_d     = found_q;
    under_d     = under_q;
    lo_d        = lo_q;
    fw_d        = fw_q;
    win_d       = win_q;
    base_d      = base_q;
    sk_d        = sk_q;
    cat_d       = cat_q;
    sc_d        = sc_q;
    sb_d        = sb_q;
    pct_d       = pct_q;
    div_go_d    = div_go_q;
    div_start   = 1'b0;
    t_we        = 1'b0;
    c_we        = 1'b0;
    t_wa        = base_addr_q + AW'(chk_idx_q);
    t_wd        = item_q.sample_time;
    t_ra        = base_addr_q + AW'(idx_q[IW-1:0]);
    c_ra        = base_addr_q + AW'(best_q[fw_q]);
    stat_o.ready = (state_q != cuwa_pkg::ST_CLEAR);
    stat_o.pop   = 1'b0;
    case (state_q)
      cuwa_pkg::ST_CLEAR: begin
        t_we = 1'b1;
        t_wa = clr_q;
        t_wd = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(cuwa_pkg::NENT - 1)) begin
          state_d = cuwa_pkg::ST_IDLE;
        end
      end
      cuwa_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          stat_o.pop  = 1'b1;
          item_d      = item_i;
          base_addr_d = AW'(32'(item_i.cpu_index) * cuwa_pkg::HIST_DEPTH);
          idx_d       = '0;
          chk_v_d     = 1'b0;
          stored_d    = 1'b0;
          cur_d       = '0;
          found_d     = '0;
          sk_d        = '0;
          sc_d        = '0;
          cat_d       = '0;
          win_d       = '0;
          fw_d        = '0;
          div_go_d    = 1'b0;
          for (int w = 0; w < NW; w++) begin
            btime_d[w] = {1'b0, item_i.sample_time} + (TW+1)'(1);
            under_d[w] = item_i.sample_time < TW'(win_i[w]);
            lo_d[w]    = item_i.sample_time - TW'(win_i[w]);
            base_d[w]  = '0;
            sb_d[w]    = '0;
          end
          state_d = item_i.slot_ok ? cuwa_pkg::ST_SCAN1 : cuwa_pkg::ST_SUM;
        end
      end
      cuwa_pkg::ST_SCAN1: begin
        if (chk_v_q && free) begin
          t_we     = 1'b1;
          c_we     = 1'b1;
          stored_d = 1'b1;
          cur_d    = item_q.ticks;
          idx_d    = '0;
          chk_v_d  = 1'b0;
          state_d  = cuwa_pkg::ST_SCAN2;
        end else if (idx_q < (IW+1)'(cuwa_pkg::HIST_DEPTH)) begin
          idx_d     = idx_q + (IW+1)'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            idx_d   = '0;
            state_d = cuwa_pkg::ST_SCAN2;
          end
        end
      end
      cuwa_pkg::ST_SCAN2: begin
        if (chk_v_q && (t_rd_q != '0)) begin
          for (int w = 0; w < NW; w++) begin
            if ((under_q[w] || (t_rd_q >= lo_q[w])) && ({1'b0, t_rd_q} < btime_q[w])) begin
              btime_d[w] = {1'b0, t_rd_q};
              best_d[w]  = chk_idx_q;
              found_d[w] = 1'b1;
            end
          end
        end
        if (idx_q < (IW+1)'(cuwa_pkg::HIST_DEPTH)) begin
          idx_d     = idx_q + (IW+1)'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            fw_d    = '0;
            state_d = cuwa_pkg::ST_FETCH_RD;
          end
        end
      end
      cuwa_pkg::ST_FETCH_RD: begin
        if (found_q[fw_q]) begin
          state_d = cuwa_pkg::ST_FETCH_WT;
        end else if (fw_q == 2'(NW - 1)) begin
          state_d = cuwa_pkg::ST_SUM;
        end else begin
          fw_d = fw_q + 2'd1;
        end
      end
      cuwa_pkg::ST_FETCH_WT: begin
        base_d[fw_q] = c_rd_q;
        if (fw_q == 2'(NW - 1)) begin
          state_d = cuwa_pkg::ST_SUM;
        end else begin
          fw_d    = fw_q + 2'd1;
          state_d = cuwa_pkg::ST_FETCH_RD;
        end
      end
      cuwa_pkg::ST_SUM: begin
        sc_d = sc_q + cuwa_pkg::SUM_W'(cur_q[sk_q]);
        for (int w = 0; w < NW; w++) begin
          sb_d[w] = sb_q[w] + cuwa_pkg::SUM_W'(base_q[w][sk_q]);
        end
        sk_d = sk_q + 3'd1;
        if (sk_q == cuwa_pkg::LAST_CAT) begin
          state_d = cuwa_pkg::ST_DIV;
        end
      end
      cuwa_pkg::ST_DIV: begin
        if (!div_go_q) begin
          div_start = 1'b1;
          div_go_d  = 1'b1;
        end else if (div_done) begin
          pct_d[win_q] = div_q;
          div_go_d     = 1'b0;
          if (win_q == 2'(NW - 1)) begin
            win_d   = '0;
            state_d = cuwa_pkg::ST_EMIT;
          end else begin
            win_d = win_q + 2'd1;
          end
        end
      end
      cuwa_pkg::ST_EMIT: begin
        if (res_ready_i) begin
          if (cat_q == cuwa_pkg::LAST_CAT) begin
            state_d = cuwa_pkg::ST_IDLE;
          end else begin
            cat_d   = cat_q + 3'd1;
            state_d = cuwa_pkg::ST_DIV;
          end
        end
      end
      default: state_d = cuwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    base_addr_q <= base_addr_d;
    item_q      <= item_d;
    cur_q       <= cur_d;
    btime_q     <= btime_d;
    best_q      <= best_d;
    under_q     <= under_d;
    lo_q        <= lo_d;
    base_q      <= base_d;
    sc_q        <= sc_d;
    sb_q        <= sb_d;
    pct_q       <= pct_d;
    stored_q    <= stored_d;
    found_q     <= found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cuwa_pkg::ST_CLEAR;
      clr_q    <= '0;
      idx_q    <= '0;
      chk_v_q  <= 1'b0;
      fw_q     <= '0;
      win_q    <= '0;
      sk_q     <= '0;
      cat_q    <= '0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      idx_q    <= idx_d;
      chk_v_q  <= chk_v_d;
      fw_q     <= fw_d;
      win_q    <= win_d;
      sk_q     <= sk_d;
      cat_q    <= cat_d;
      div_go_q <= div_go_d;
    end
  end

endmodule

[src/cpu_utilization_window_averager.sv]
// Top level: window registers, input queue and averaging engine.
//
//  port group  | dir | content
//  s_axis      | in  | one sample: slot, time, eight tick counters
//  m_axis      | out | one category result, tlast on category 7
//  cfg         | in  | window lengths, index 0 short, 1 mid, 2 long
//
// An item passes through the two history scans, the fetch of up to three
// window bases, the sums over the eight categories and 24 divisions (eight
// categories by three windows). After reset a pass clears the 9216-entry
// time memory with s_axis_tready low. A stalled m_axis holds the engine;
// two samples queue.
module cpu_utilization_window_averager (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cpu_index, sample_time, user, system, nice, idle, interrupt, iowait,
  // softirq, steal ticks, zero pad
  input  logic [cuwa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // category, pct_short, pct_mid, pct_long, stored, zero pad
  output logic [cuwa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [cuwa_pkg::WIN_W-1:0]      cfg_data_i
);

  logic [cuwa_pkg::WIN_W-1:0] win_q [cuwa_pkg::NWIN];
  logic [cuwa_pkg::PCT_W-1:0] pct [cuwa_pkg::NWIN];
  logic [cuwa_pkg::CAT_W-1:0] cat;
  logic                       stored;
  logic                       item_valid;
  cuwa_pkg::item_t            item;
  cuwa_pkg::eng_stat_t        stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= 16'd60;
      win_q[1] <= 16'd300;
      win_q[2] <= 16'd900;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cuwa_pkg::CFG_WIN_SHORT: win_q[0] <= cfg_data_i;
        cuwa_pkg::CFG_WIN_MID:   win_q[1] <= cfg_data_i;
        cuwa_pkg::CFG_WIN_LONG:  win_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cuwa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .stat_i        (stat),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  cuwa_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_i        (win_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .stat_o       (stat),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_cat_o    (cat),
    .res_pct_o    (pct),
    .res_stored_o (stored),
    .res_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, stored, pct[2], pct[1], pct[0], cat};

endmodule

[src/cuwa_checker.sv]
// Port-level checks of the averager output stream.
module cuwa_assert (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cuwa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == cuwa_pkg::LAST_CAT)))
    else $error("tlast not on last category");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:3] <= cuwa_pkg::FULL_SCALE)
      && (m_axis_tdata[32:18] <= cuwa_pkg::FULL_SCALE)
      && (m_axis_tdata[47:33] <= cuwa_pkg::FULL_SCALE))
    else $error("percentage above full scale");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || (m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1))
    else $error("category out of order");

endmodule

bind cpu_utilization_window_averager cuwa_assert u_cuwa_assert (.*);

[bench/cuwa_checker.sv]
// Checker for the window averager: watches the streams, predicts results and compares them.
module cuwa_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [cuwa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [cuwa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [cuwa_pkg::WIN_W-1:0]      cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct {
    bit [cuwa_pkg::CAT_W-1:0] cat;
    bit [cuwa_pkg::PCT_W-1:0] pct [cuwa_pkg::NWIN];
    bit                       stored;
    bit                       last;
  } cat_result_t;

  bit [cuwa_pkg::TIME_W-1:0] hist_time [cuwa_pkg::NENT];
  bit [cuwa_pkg::CNT_W-1:0]  hist_ticks [cuwa_pkg::NENT][cuwa_pkg::NCAT];
  bit [cuwa_pkg::WIN_W-1:0]  win_len [cuwa_pkg::NWIN];
  cat_result_t               result_q [$];

  function automatic bit [cuwa_pkg::PCT_W-1:0] share_pct(
      bit [cuwa_pkg::CNT_W-1:0] cur, bit [cuwa_pkg::CNT_W-1:0] base,
      bit [cuwa_pkg::SUM_W-1:0] sum_cur, bit [cuwa_pkg::SUM_W-1:0] sum_base);
    bit [95:0] dt;
    bit [95:0] da;
    bit [95:0] q;
    if (!(cur > base) || !(sum_cur > sum_base)) return '0;
    dt = 96'(cur - base);
    da = 96'(sum_cur) - 96'(sum_base);
    if (da <= dt) return cuwa_pkg::FULL_SCALE;
    q = (dt * 96'd25600) / da;
    return q[cuwa_pkg::PCT_W-1:0];
  endfunction

  task automatic predict_sample(bit [cuwa_pkg::IN_DATA_W-1:0] d);
    bit [cuwa_pkg::SLOT_W-1:0] slot;
    longint                    now;
    longint                    t;
    longint                    btime [cuwa_pkg::NWIN];
    bit [cuwa_pkg::CNT_W-1:0]  cur [cuwa_pkg::NCAT];
    bit [cuwa_pkg::CNT_W-1:0]  base [cuwa_pkg::NWIN][cuwa_pkg::NCAT];
    bit [cuwa_pkg::SUM_W-1:0]  sum_cur;
    bit [cuwa_pkg::SUM_W-1:0]  sum_base [cuwa_pkg::NWIN];
    bit                        stored;
    int                        off;
    cat_result_t               r;
    slot = d[3:0];
    now = longint'(d[35:4]);
    stored = 0;
    foreach (cur[k]) cur[k] = '0;
    foreach (base[w, k]) base[w][k] = '0;
    if (slot <= cuwa_pkg::NUM_CPUS) begin
      off = int'(slot) * cuwa_pkg::HIST_DEPTH;
      for (int i = 0; i < cuwa_pkg::HIST_DEPTH; i++) begin
        if (longint'(hist_time[off+i]) + cuwa_pkg::HIST_DEPTH < now) begin
          hist_time[off+i] = now[31:0];
          for (int k = 0; k < cuwa_pkg::NCAT; k++) begin
            cur[k] = d[36+64*k +: 64];
            hist_ticks[off+i][k] = cur[k];
          end
          stored = 1;
          break;
        end
      end
      foreach (btime[w]) btime[w] = now + 1;
      for (int i = 0; i < cuwa_pkg::HIST_DEPTH; i++) begin
        t = longint'(hist_time[off+i]);
        if (t != 0) begin
          for (int w = 0; w < cuwa_pkg::NWIN; w++) begin
            if (t >= now - longint'(win_len[w]) && btime[w] > t) begin
              btime[w] = t;
              for (int k = 0; k < cuwa_pkg::NCAT; k++) base[w][k] = hist_ticks[off+i][k];
            end
          end
        end
      end
    end
    sum_cur = '0;
    foreach (cur[k]) sum_cur += cuwa_pkg::SUM_W'(cur[k]);
    for (int w = 0; w < cuwa_pkg::NWIN; w++) begin
      sum_base[w] = '0;
      for (int k = 0; k < cuwa_pkg::NCAT; k++) sum_base[w] += cuwa_pkg::SUM_W'(base[w][k]);
    end
    for (int k = 0; k < cuwa_pkg::NCAT; k++) begin
      r.cat = k[cuwa_pkg::CAT_W-1:0];
      for (int w = 0; w < cuwa_pkg::NWIN; w++)
        r.pct[w] = share_pct(cur[k], base[w][k], sum_cur, sum_base[w]);
      r.stored = stored;
      r.last = (r.cat == cuwa_pkg::LAST_CAT);
      result_q.push_back(r);
    end
  endtask

  task automatic compare_beat(bit [cuwa_pkg::OUT_DATA_W-1:0] d, bit tl);
    cat_result_t              e;
    bit [cuwa_pkg::PCT_W-1:0] got;
    if (result_q.size() == 0) begin
      $display("%0t unexpected beat: expected none, actual %h last %b", $time, d, tl);
      fail_count_o++;
      return;
    end
    e = result_q.pop_front();
    if (d[2:0] != e.cat) begin
      $display("%0t category: expected %0d, actual %0d", $time, e.cat, d[2:0]);
      fail_count_o++;
    end
    for (int w = 0; w < cuwa_pkg::NWIN; w++) begin
      got = d[3+cuwa_pkg::PCT_W*w +: cuwa_pkg::PCT_W];
      if (got != e.pct[w]) begin
        $display("%0t cat %0d pct[%0d]: expected %0d, actual %0d",
                 $time, e.cat, w, e.pct[w], got);
        fail_count_o++;
      end
    end
    if (d[48] != e.stored) begin
      $display("%0t cat %0d stored: expected %b, actual %b", $time, e.cat, e.stored, d[48]);
      fail_count_o++;
    end
    if (tl != e.last) begin
      $display("%0t cat %0d last: expected %b, actual %b", $time, e.cat, e.last, tl);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist_time[i]) hist_time[i] = '0;
      win_len[cuwa_pkg::CFG_WIN_SHORT] = 16'd60;
      win_len[cuwa_pkg::CFG_WIN_MID] = 16'd300;
      win_len[cuwa_pkg::CFG_WIN_LONG] = 16'd900;
      result_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_beat(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata);
      if (cfg_we_i && cfg_idx_i <= cuwa_pkg::CFG_WIN_LONG) win_len[cfg_idx_i] = cfg_data_i;
      pending_o = result_q.size();
    end
  end
endmodule

[bench/cpu_utilization_window_averager_tb.sv]
// Testbench top for the window averager: clock, reset, stimulus and verdict.
module cpu_utilization_window_averager_tb;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                            clk_i = 0;
  logic                            rst_ni = 0;
  logic                            s_axis_tvalid = 0;
  logic                            s_axis_tready;
  logic [cuwa_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 0;
  logic [cuwa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_we_i = 0;
  logic [1:0]                      cfg_idx_i = cuwa_pkg::CFG_WIN_SHORT;
  logic [cuwa_pkg::WIN_W-1:0]      cfg_data_i = '0;
  int                              fail_count;
  int                              pending;
  int                              quiet_cycles = 0;
  bit                              idle_on = 1;
  bit [cuwa_pkg::TIME_W-1:0]       slot_time [cuwa_pkg::NSLOT];
  bit [cuwa_pkg::CNT_W-1:0]        slot_ticks [cuwa_pkg::NSLOT][cuwa_pkg::NCAT];

  always #5 clk_i = ~clk_i;

  cpu_utilization_window_averager dut (.*);

  cuwa_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (idle_on) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(bit [3:0] slot, bit [31:0] t,
                             bit [cuwa_pkg::CNT_W-1:0] c [cuwa_pkg::NCAT]);
    bit [cuwa_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[3:0] = slot;
    d[35:4] = t;
    for (int k = 0; k < cuwa_pkg::NCAT; k++) d[36+64*k +: 64] = c[k];
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_windows(bit [cuwa_pkg::WIN_W-1:0] ws, bit [cuwa_pkg::WIN_W-1:0] wm,
                               bit [cuwa_pkg::WIN_W-1:0] wl);
    drain();
    cfg_we_i <= 1; cfg_idx_i <= cuwa_pkg::CFG_WIN_SHORT; cfg_data_i <= ws;
    @(posedge clk_i);
    cfg_idx_i <= cuwa_pkg::CFG_WIN_MID; cfg_data_i <= wm;
    @(posedge clk_i);
    cfg_idx_i <= cuwa_pkg::CFG_WIN_LONG; cfg_data_i <= wl;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_fill(bit [3:0] slot, bit [31:0] t, bit [cuwa_pkg::CNT_W-1:0] v);
    bit [cuwa_pkg::CNT_W-1:0] c [cuwa_pkg::NCAT];
    foreach (c[k]) c[k] = v;
    send_sample(slot, t, c);
  endtask

  task automatic send_tracked(int slot);
    bit [cuwa_pkg::CNT_W-1:0] c [cuwa_pkg::NCAT];
    slot_time[slot] += $urandom_range(1, 40);
    for (int k = 0; k < cuwa_pkg::NCAT; k++) begin
      slot_ticks[slot][k] += $urandom_range(0, 1000) * ($urandom_range(0, 5) == 0 ? 0 : 1);
      c[k] = slot_ticks[slot][k];
    end
    send_sample(4'(slot), slot_time[slot], c);
  endtask

  task automatic send_noise;
    bit [cuwa_pkg::CNT_W-1:0] c [cuwa_pkg::NCAT];
    foreach (c[k]) c[k] = {$urandom, $urandom};
    send_sample(4'($urandom_range(0, 15)), $urandom_range(1, 32'hFFFF_FFFF), c);
  endtask

  task automatic random_run(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_tracked($urandom_range(0, cuwa_pkg::NUM_CPUS));
    end
  endtask

  initial begin
    bit [cuwa_pkg::CNT_W-1:0] c [cuwa_pkg::NCAT];
    foreach (slot_time[s]) slot_time[s] = 32'd1100 + $urandom_range(0, 200);
    foreach (slot_ticks[s, k]) slot_ticks[s][k] = {$urandom, $urandom} >> 2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    send_fill(0, 32'd5, 64'd100);
    send_fill(9, 32'd2000, 64'd7);
    send_fill(15, 32'hFFFF_FFFF, '1);
    send_fill(1, 32'd2000, 64'd0);
    send_fill(1, 32'd2010, 64'd500);
    send_fill(1, 32'd2010, 64'd900);
    send_fill(1, 32'd2011, 64'd300);
    foreach (c[k]) c[k] = 64'd1000;
    send_sample(2, 32'd3000, c);
    c[0] = 64'd1100; c[3] = 64'd950;
    send_sample(2, 32'd3030, c);
    c[1] = 64'd5000; c[7] = 64'd1;
    send_sample(2, 32'd3500, c);
    send_fill(8, 32'hFFFF_FFFF, '1);
    send_fill(8, 32'hFFFF_FFFF, '0);
    foreach (c[k]) c[k] = 64'h5555_5555_5555_5555 << (k % 2);
    send_sample(3, 32'hAAAA_AAAA, c);
    foreach (c[k]) c[k] = ~c[k];
    send_sample(3, 32'hAAAA_AAAB, c);

    write_windows(16'd1, 16'd65535, 16'd2);
    send_fill(2, 32'd3501, 64'd6000);
    send_fill(2, 32'd3502, 64'd6001);
    send_fill(4, 32'h5555_5555, 64'd10);
    send_fill(4, 32'h5555_5556, 64'd12);

    write_windows(16'd65535, 16'd65535, 16'd65535);
    random_run(40);

    write_windows(16'($urandom_range(1, 60)), 16'($urandom_range(20, 200)),
                  16'($urandom_range(100, 600)));
    random_run(40);

    write_windows(16'd1, 16'd30, 16'd120);
    idle_on = 0;
    random_run(40);

    drain();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
